// ===== rtl/two_axis_slew_positioner_assert.svh =====
// Assertion macros for the two-axis slew positioner.
// Used by the top level only; no other dependencies.
`ifndef TWO_AXIS_SLEW_POSITIONER_ASSERT_SVH
`define TWO_AXIS_SLEW_POSITIONER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TASP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("two_axis_slew_positioner: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TASP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("two_axis_slew_positioner: next-cycle check failed");

`endif

// ===== rtl/tasp_pkg.sv =====
// Types, codes and constants for the two-axis slew positioner.
// Depends on nothing; used by the top level.
`default_nettype none

package tasp_pkg;

    typedef logic [2:0]         action_t;
    typedef logic [1:0]         link_t;
    typedef logic [1:0]         status_t;
    typedef logic [1:0]         cfg_index_t;
    typedef logic [15:0]        cfg_data_t;
    typedef logic [15:0]        az_t;
    typedef logic signed [14:0] el_t;
    typedef logic signed [15:0] el_in_t;
    typedef logic [15:0]        rate_t;
    typedef logic [15:0]        step_t;
    typedef logic [31:0]        count_t;

    localparam action_t ACT_TICK       = 3'd0;
    localparam action_t ACT_COMMAND    = 3'd1;
    localparam action_t ACT_STOP       = 3'd2;
    localparam action_t ACT_TRIGGER    = 3'd3;
    localparam action_t ACT_CONNECT    = 3'd4;
    localparam action_t ACT_DISCONNECT = 3'd5;
    localparam action_t ACT_SNAP       = 3'd6;
    localparam action_t ACT_FAULT      = 3'd7;

    localparam link_t LINK_DOWN = 2'd0;
    localparam link_t LINK_UP   = 2'd1;
    localparam link_t LINK_ERR  = 2'd2;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NO_LINK = 2'd1;
    localparam status_t ST_CLAMPED = 2'd2;

    localparam cfg_index_t CFG_EL_LOW  = 2'd0;
    localparam cfg_index_t CFG_EL_HIGH = 2'd1;
    localparam cfg_index_t CFG_AZ_RATE = 2'd2;
    localparam cfg_index_t CFG_EL_RATE = 2'd3;

    localparam el_t   EL_LOW_RST  = 15'sd0;
    localparam el_t   EL_HIGH_RST = 15'sd8500;
    localparam rate_t AZ_RATE_RST = 16'd1000;
    localparam rate_t EL_RATE_RST = 16'd500;

    localparam az_t                AZ_FULL   = 16'd36000;
    localparam logic signed [17:0] AZ_FULL_S = 18'sd36000;
    localparam logic signed [17:0] AZ_HALF_S = 18'sd18000;

    // x / 1000 is computed as (x >> 3) / 125 with a 2^-36 scaled reciprocal.
    localparam logic [29:0] RECIP_125   = 30'd549755814;
    localparam int          RECIP_SHIFT = 36;

    // Slew step in centidegrees, saturated to 16 bits, which exceeds any axis distance.
    function automatic step_t div1000_sat(input logic [31:0] prod);
        logic [58:0] scaled;
        logic [22:0] quot;
        scaled = 59'(prod[31:3]) * 59'(RECIP_125);
        quot   = scaled[58:RECIP_SHIFT];
        return (|quot[22:16]) ? 16'hFFFF : quot[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/two_axis_slew_positioner.sv =====
// Two-axis slew positioner: command decode, slew step pipeline and position state.
// Depends on tasp_pkg and two_axis_slew_positioner_assert.svh.
// Words pass the input, rate product and reciprocal divide stages, then the output
// register. Throughput: one word per cycle, unless m_ready low stalls the output.
// Reset (aresetn low at a clock edge) empties the pipeline, zeroes positions, targets
// and counters, drops the link and loads the register defaults; no clearing pass.
`default_nettype none

module two_axis_slew_positioner (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_wr_en,
    input  tasp_pkg::cfg_index_t   cfg_index,
    input  tasp_pkg::cfg_data_t    cfg_wr_data,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  tasp_pkg::action_t      s_action,
    input  tasp_pkg::az_t          s_azimuth_in,
    input  tasp_pkg::el_in_t       s_elevation_in,
    input  wire [15:0]             s_delta_ms,
    output logic                   m_valid,
    input  wire                    m_ready,
    output tasp_pkg::status_t      m_status,
    output tasp_pkg::az_t          m_azimuth_now,
    output tasp_pkg::el_t          m_elevation_now,
    output logic                   m_moving,
    output tasp_pkg::link_t        m_link_state,
    output tasp_pkg::count_t       m_event_count,
    output tasp_pkg::count_t       m_elapsed_ms
);
    import tasp_pkg::*;

    el_t    el_low_reg;
    el_t    el_high_reg;
    rate_t  az_rate_reg;
    rate_t  el_rate_reg;

    az_t    az_pos_reg, az_pos_next;
    el_t    el_pos_reg, el_pos_next;
    az_t    az_goal_reg, az_goal_next;
    el_t    el_goal_reg, el_goal_next;
    link_t  link_reg, link_next;
    count_t events_reg, events_next;
    count_t time_reg, time_next;

    logic         a_valid_reg;
    action_t      a_action_reg;
    az_t          a_az_reg;
    el_in_t       a_el_reg;
    logic [15:0]  a_dt_reg;

    logic         b_valid_reg;
    action_t      b_action_reg;
    az_t          b_az_reg;
    el_t          b_el_reg;
    logic         b_clamped_reg;
    logic [15:0]  b_dt_reg;
    logic [31:0]  b_az_prod_reg;
    logic [31:0]  b_el_prod_reg;

    logic         c_valid_reg;
    action_t      c_action_reg;
    az_t          c_az_reg;
    el_t          c_el_reg;
    logic         c_clamped_reg;
    logic [15:0]  c_dt_reg;
    step_t        c_az_step_reg;
    step_t        c_el_step_reg;

    logic         out_valid_reg;
    status_t      status_reg, status_next;
    logic         moving_reg, moving_next;

    logic out_adv, out_load, c_ready, b_ready, a_ready;

    assign out_adv  = !out_valid_reg || m_ready;
    assign out_load = out_adv && c_valid_reg;
    assign c_ready  = !c_valid_reg || out_adv;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_ready  = a_ready;

    // Request reduction and elevation clamp, in the same stage as the rate products.
    el_t    lim_lo, lim_hi;
    el_in_t lim_lo_x, lim_hi_x;
    az_t    az_req;
    el_t    el_req;
    logic   el_clamped;

    assign lim_lo   = (el_low_reg < el_high_reg) ? el_low_reg : el_high_reg;
    assign lim_hi   = (el_low_reg < el_high_reg) ? el_high_reg : el_low_reg;
    assign lim_lo_x = {lim_lo[14], lim_lo};
    assign lim_hi_x = {lim_hi[14], lim_hi};
    assign az_req   = (a_az_reg >= AZ_FULL) ? (a_az_reg - AZ_FULL) : a_az_reg;

    always_comb begin
        el_clamped = 1'b0;
        el_req     = a_el_reg[14:0];
        if (a_el_reg < lim_lo_x) begin
            el_clamped = 1'b1;
            el_req     = lim_lo;
        end else if (a_el_reg > lim_hi_x) begin
            el_clamped = 1'b1;
            el_req     = lim_hi;
        end
    end

    // Azimuth step along the shortest way round the circle.
    logic signed [17:0] az_pos_s, az_goal_s, az_step_s, az_d, az_dw, az_sum, az_dif;
    logic               az_reach;
    az_t                az_slewed;

    assign az_pos_s  = {2'b00, az_pos_reg};
    assign az_goal_s = {2'b00, az_goal_reg};
    assign az_step_s = {2'b00, c_az_step_reg};
    assign az_d      = az_goal_s - az_pos_s;
    assign az_sum    = az_pos_s + az_step_s;
    assign az_dif    = az_pos_s - az_step_s;
    assign az_reach  = (az_dw <= az_step_s) && (-az_dw <= az_step_s);

    always_comb begin
        if (az_d >= AZ_HALF_S) begin
            az_dw = az_d - AZ_FULL_S;
        end else if (az_d < -AZ_HALF_S) begin
            az_dw = az_d + AZ_FULL_S;
        end else begin
            az_dw = az_d;
        end
        if (az_reach) begin
            az_slewed = az_goal_reg;
        end else if (az_dw > 18'sd0) begin
            az_slewed = (az_sum >= AZ_FULL_S) ? 16'(az_sum - AZ_FULL_S) : az_sum[15:0];
        end else begin
            az_slewed = (az_dif < 18'sd0) ? 16'(az_dif + AZ_FULL_S) : az_dif[15:0];
        end
    end

    // Elevation step, linear.
    logic signed [16:0] el_pos_s, el_goal_s, el_step_s, el_d, el_move;
    logic               el_reach;
    el_t                el_slewed;

    assign el_pos_s  = {{2{el_pos_reg[14]}}, el_pos_reg};
    assign el_goal_s = {{2{el_goal_reg[14]}}, el_goal_reg};
    assign el_step_s = {1'b0, c_el_step_reg};
    assign el_d      = el_goal_s - el_pos_s;
    assign el_reach  = (el_d <= el_step_s) && (-el_d <= el_step_s);
    assign el_move   = (el_d > 17'sd0) ? (el_pos_s + el_step_s) : (el_pos_s - el_step_s);
    assign el_slewed = el_reach ? el_goal_reg : el_move[14:0];

    logic link_up;
    assign link_up = (link_reg == LINK_UP);

    always_comb begin
        az_pos_next  = az_pos_reg;
        el_pos_next  = el_pos_reg;
        az_goal_next = az_goal_reg;
        el_goal_next = el_goal_reg;
        link_next    = link_reg;
        events_next  = events_reg;
        time_next    = time_reg;
        status_next  = ST_OK;
        unique case (c_action_reg)
            ACT_TICK: begin
                if (link_up && (c_dt_reg != 16'd0)) begin
                    time_next   = time_reg + {16'd0, c_dt_reg};
                    az_pos_next = az_slewed;
                    el_pos_next = el_slewed;
                end
            end
            ACT_COMMAND: begin
                if (!link_up) begin
                    status_next = ST_NO_LINK;
                end else begin
                    az_goal_next = c_az_reg;
                    el_goal_next = c_el_reg;
                    if (c_clamped_reg) begin
                        status_next = ST_CLAMPED;
                    end
                end
            end
            ACT_STOP: begin
                if (!link_up) begin
                    status_next = ST_NO_LINK;
                end else begin
                    az_goal_next = az_pos_reg;
                    el_goal_next = el_pos_reg;
                end
            end
            ACT_TRIGGER: begin
                if (!link_up) begin
                    status_next = ST_NO_LINK;
                end else begin
                    events_next = events_reg + 32'd1;
                end
            end
            ACT_CONNECT: begin
                link_next   = LINK_UP;
                events_next = '0;
            end
            ACT_DISCONNECT: begin
                link_next    = LINK_DOWN;
                az_goal_next = az_pos_reg;
                el_goal_next = el_pos_reg;
            end
            ACT_SNAP: begin
                az_pos_next  = c_az_reg;
                az_goal_next = c_az_reg;
                el_pos_next  = c_el_reg;
                el_goal_next = c_el_reg;
            end
            ACT_FAULT: begin
                link_next = LINK_ERR;
            end
        endcase
        moving_next = (link_next == LINK_UP)
                   && ((az_pos_next != az_goal_next) || (el_pos_next != el_goal_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            el_low_reg    <= EL_LOW_RST;
            el_high_reg   <= EL_HIGH_RST;
            az_rate_reg   <= AZ_RATE_RST;
            el_rate_reg   <= EL_RATE_RST;
            az_pos_reg    <= '0;
            el_pos_reg    <= '0;
            az_goal_reg   <= '0;
            el_goal_reg   <= '0;
            link_reg      <= LINK_DOWN;
            events_reg    <= '0;
            time_reg      <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_EL_LOW:  el_low_reg  <= cfg_wr_data[14:0];
                    CFG_EL_HIGH: el_high_reg <= cfg_wr_data[14:0];
                    CFG_AZ_RATE: az_rate_reg <= cfg_wr_data;
                    CFG_EL_RATE: el_rate_reg <= cfg_wr_data;
                endcase
            end
            if (out_load) begin
                az_pos_reg  <= az_pos_next;
                el_pos_reg  <= el_pos_next;
                az_goal_reg <= az_goal_next;
                el_goal_reg <= el_goal_next;
                link_reg    <= link_next;
                events_reg  <= events_next;
                time_reg    <= time_next;
            end
            if (a_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_adv) begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_valid) begin
            a_action_reg <= s_action;
            a_az_reg     <= s_azimuth_in;
            a_el_reg     <= s_elevation_in;
            a_dt_reg     <= s_delta_ms;
        end
        if (b_ready && a_valid_reg) begin
            b_action_reg  <= a_action_reg;
            b_az_reg      <= az_req;
            b_el_reg      <= el_req;
            b_clamped_reg <= el_clamped;
            b_dt_reg      <= a_dt_reg;
            b_az_prod_reg <= {16'd0, az_rate_reg} * {16'd0, a_dt_reg};
            b_el_prod_reg <= {16'd0, el_rate_reg} * {16'd0, a_dt_reg};
        end
        if (c_ready && b_valid_reg) begin
            c_action_reg  <= b_action_reg;
            c_az_reg      <= b_az_reg;
            c_el_reg      <= b_el_reg;
            c_clamped_reg <= b_clamped_reg;
            c_dt_reg      <= b_dt_reg;
            c_az_step_reg <= div1000_sat(b_az_prod_reg);
            c_el_step_reg <= div1000_sat(b_el_prod_reg);
        end
        if (out_load) begin
            status_reg <= status_next;
            moving_reg <= moving_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = status_reg;
    assign m_azimuth_now   = az_pos_reg;
    assign m_elevation_now = el_pos_reg;
    assign m_moving        = moving_reg;
    assign m_link_state    = link_reg;
    assign m_event_count   = events_reg;
    assign m_elapsed_ms    = time_reg;

`include "two_axis_slew_positioner_assert.svh"

    `TASP_ASSERT_NOW(a_az_range, aclk, aresetn, 1'b1,
        (az_pos_reg < AZ_FULL) && (az_goal_reg < AZ_FULL))
    `TASP_ASSERT_NOW(a_moving_link, aclk, aresetn, out_valid_reg && moving_reg,
        link_reg == LINK_UP)
    `TASP_ASSERT_NOW(a_no_link_status, aclk, aresetn,
        out_valid_reg && (status_reg == ST_NO_LINK), link_reg != LINK_UP)
    `TASP_ASSERT_NEXT(a_connect_clears, aclk, aresetn,
        out_load && (c_action_reg == ACT_CONNECT),
        (events_reg == 32'd0) && (link_reg == LINK_UP))

endmodule

`default_nettype wire
